// File: sv/ufd_pkg.sv
// ---------------------------------------------------------------------------
// ufd_pkg
// shared types and character constants of the form field decoder
// ---------------------------------------------------------------------------
package ufd_pkg;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_D = 8'h44;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] HEX_ALPHA_OFS = 8'd55;
    localparam logic [7:0] HEX_DIGIT_OFS = 8'd48;

    localparam logic [1:0] KIND_NAME  = 2'd0;
    localparam logic [1:0] KIND_VALUE = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    typedef enum logic [2:0] {
        ESC_NONE    = 3'b001,
        ESC_PERCENT = 3'b010,
        ESC_HIGH    = 3'b100
    } t_esc_state;

    typedef enum logic [3:0] {
        NL_NONE    = 4'b0001,
        NL_CR      = 4'b0010,
        NL_PERCENT = 4'b0100,
        NL_ZERO    = 4'b1000
    } t_nl_state;

    localparam int SLOTS = 3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] item_kind;
        logic       last_of_run;
    } t_out;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] item_kind;
    } t_slot;

    typedef struct packed {
        logic [1:0]             count;
        t_slot [SLOTS-1:0]      slots;
    } t_bundle;

endpackage

// File: sv/ufd_front.sv
// ---------------------------------------------------------------------------
// ufd_front
// takes one encoded byte per cycle unless the queue is full, tracks escape
// and pair state; each byte becomes a bundle of up to three decoded results
// ---------------------------------------------------------------------------
module ufd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  ufd_pkg::t_in     i_in_data,
    output logic             o_in_stall,
    input  logic             i_q_full,
    output logic             o_q_push,
    output ufd_pkg::t_bundle o_q_data
);
    import ufd_pkg::*;

    typedef struct packed {
        logic       ok;
        logic [7:0] b;
        logic [1:0] k;
        logic       iv;
    } t_emit;

    logic       r_iv, n_iv;
    t_esc_state r_ep, n_ep;
    logic [7:0] r_hd, n_hd;
    t_nl_state  r_nl, n_nl;

    logic       accept;
    logic [7:0] b;
    logic [7:0] dig_h;
    logic [7:0] dig_l;
    logic [7:0] dec;
    logic [1:0] cnt;
    t_slot [SLOTS-1:0] slots;
    t_emit      e;

    function automatic logic [7:0] digit_of(input logic [7:0] c);
        return (c > CH_NINE) ? (c - HEX_ALPHA_OFS) : (c - HEX_DIGIT_OFS);
    endfunction

    function automatic t_emit emit_decoded(input logic [7:0] d, input logic iv);
        t_emit r;
        r.ok = 1'b1;
        r.b  = d;
        r.k  = KIND_VALUE;
        r.iv = iv;
        if (!iv) begin
            r.k = KIND_NAME;
            if (d == CH_EQUAL) begin
                r.ok = 1'b0;
                r.iv = 1'b1;
            end else if (d >= CH_UPPER_A && d <= CH_UPPER_Z) begin
                r.b = d + 8'd32;
            end
        end
        return r;
    endfunction

    assign accept     = i_in_valid && !i_q_full;
    assign o_in_stall = i_q_full;
    assign b          = i_in_data.in_byte;
    assign dig_h      = digit_of(r_hd);
    assign dig_l      = digit_of(b);
    assign dec        = {dig_h[3:0], 4'h0} + dig_l;

    always_comb begin
        n_iv  = r_iv;
        n_ep  = r_ep;
        n_hd  = r_hd;
        n_nl  = r_nl;
        cnt   = 2'd0;
        slots = '0;
        e     = '0;

        if (r_ep == ESC_PERCENT) begin
            n_hd = b;
            n_ep = ESC_HIGH;
            if (r_nl == NL_PERCENT) begin
                if (b == CH_ZERO) begin
                    n_nl = NL_ZERO;
                end else begin
                    n_nl = NL_CR;
                end
            end
        end else if (r_ep == ESC_HIGH) begin
            n_ep = ESC_NONE;
            if (r_nl == NL_ZERO && b == CH_UPPER_A) begin
                n_nl = NL_NONE;
                e = emit_decoded(CH_LF, n_iv);
                n_iv = e.iv;
                if (e.ok) begin
                    slots[cnt] = '{out_byte: e.b, item_kind: e.k};
                    cnt = cnt + 2'd1;
                end
            end else begin
                if (r_nl != NL_NONE) begin
                    n_nl = NL_NONE;
                    e = emit_decoded(CH_CR, n_iv);
                    n_iv = e.iv;
                    if (e.ok) begin
                        slots[cnt] = '{out_byte: e.b, item_kind: e.k};
                        cnt = cnt + 2'd1;
                    end
                end
                if (r_hd == CH_ZERO && b == CH_UPPER_D) begin
                    n_nl = NL_CR;
                end else begin
                    e = emit_decoded(dec, n_iv);
                    n_iv = e.iv;
                    if (e.ok) begin
                        slots[cnt] = '{out_byte: e.b, item_kind: e.k};
                        cnt = cnt + 2'd1;
                    end
                end
            end
        end else begin
            n_ep = ESC_NONE;
            if (b == CH_PERCENT) begin
                n_ep = ESC_PERCENT;
                if (r_nl != NL_NONE) begin
                    n_nl = NL_PERCENT;
                end
            end else begin
                if (r_nl != NL_NONE) begin
                    n_nl = NL_NONE;
                    e = emit_decoded(CH_CR, n_iv);
                    n_iv = e.iv;
                    if (e.ok) begin
                        slots[cnt] = '{out_byte: e.b, item_kind: e.k};
                        cnt = cnt + 2'd1;
                    end
                end
                if (b == CH_AMP) begin
                    slots[cnt] = '{out_byte: 8'h00, item_kind: KIND_END};
                    cnt = cnt + 2'd1;
                    n_iv = 1'b0;
                end else begin
                    e = emit_decoded((b == CH_PLUS) ? CH_SPACE : b, n_iv);
                    n_iv = e.iv;
                    if (e.ok) begin
                        slots[cnt] = '{out_byte: e.b, item_kind: e.k};
                        cnt = cnt + 2'd1;
                    end
                end
            end
        end

        if (i_in_data.end_of_string) begin
            if (n_nl != NL_NONE) begin
                e = emit_decoded(CH_CR, n_iv);
                if (e.ok) begin
                    slots[cnt] = '{out_byte: e.b, item_kind: e.k};
                    cnt = cnt + 2'd1;
                end
            end
            slots[cnt] = '{out_byte: 8'h00, item_kind: KIND_END};
            cnt = cnt + 2'd1;
            n_iv = 1'b0;
            n_ep = ESC_NONE;
            n_hd = 8'h00;
            n_nl = NL_NONE;
        end
    end

    assign o_q_push       = accept && (cnt != 2'd0);
    assign o_q_data.count = cnt;
    assign o_q_data.slots = slots;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
            r_ep <= ESC_NONE;
            r_hd <= 8'h00;
            r_nl <= NL_NONE;
        end else if (accept) begin
            r_iv <= n_iv;
            r_ep <= n_ep;
            r_hd <= n_hd;
            r_nl <= n_nl;
        end
    end

endmodule

// File: sv/ufd_queue.sv
// ---------------------------------------------------------------------------
// ufd_queue
// small fifo of result bundles between the front and back parts
// ---------------------------------------------------------------------------
module ufd_queue #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ufd_pkg::t_bundle i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output ufd_pkg::t_bundle o_data
);
    import ufd_pkg::*;

    localparam int AW = $clog2(DEPTH);

    t_bundle       r_mem [DEPTH];
    logic [AW:0]   r_wr_ptr, n_wr_ptr;
    logic [AW:0]   r_rd_ptr, n_rd_ptr;
    logic [AW:0]   fill;

    assign fill    = r_wr_ptr - r_rd_ptr;
    assign o_full  = fill[AW];
    assign o_empty = (r_wr_ptr == r_rd_ptr);
    assign o_data  = r_mem[r_rd_ptr[AW-1:0]];

    assign n_wr_ptr = r_wr_ptr + {{AW{1'b0}}, 1'b1};
    assign n_rd_ptr = r_rd_ptr + {{AW{1'b0}}, 1'b1};

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr_ptr[AW-1:0]] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop && !o_empty) begin
                r_rd_ptr <= n_rd_ptr;
            end
        end
    end

endmodule

// File: sv/ufd_back.sv
// ---------------------------------------------------------------------------
// ufd_back
// unpacks queued bundles into single results through an output register
// ---------------------------------------------------------------------------
module ufd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  ufd_pkg::t_bundle i_q_data,
    output logic             o_q_pop,
    output logic             o_out_valid,
    output ufd_pkg::t_out    o_out_data,
    input  logic             i_out_stall
);
    import ufd_pkg::*;

    logic [1:0] r_idx, n_idx;
    logic       r_out_valid;
    t_out       r_out_data;
    logic       load;
    logic       last;
    t_slot      cur;

    assign load    = !i_q_empty && (!r_out_valid || !i_out_stall);
    assign last    = (r_idx == (i_q_data.count - 2'd1));
    assign cur     = i_q_data.slots[r_idx];
    assign o_q_pop = load && last;
    assign n_idx   = last ? 2'd0 : (r_idx + 2'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx       <= n_idx;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_data <= '{out_byte: cur.out_byte, item_kind: cur.item_kind,
                            last_of_run: last};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: sv/url_form_field_decoder_core.sv
// ---------------------------------------------------------------------------
// url_form_field_decoder_core
// url form-encoded string decoder into name, value and end-of-pair results
// ---------------------------------------------------------------------------
// One encoded byte is accepted per cycle as long as the bundle queue
// (QUEUE_DEPTH entries) has room; each byte turns in the same cycle into a
// bundle of zero to three results. Results leave one per cycle from the
// output register while i_out_stall is low; a byte with several results
// holds the output side longer and the queue absorbs the difference. An
// accepted byte is held in the queue and then in the output register.
// '+' gives a space, %HL escapes decode with upper-case hex arithmetic,
// %0D%0A gives one newline, '&' and end of string close a pair, the first
// '=' switches to the value and name letters are lower-cased.
module url_form_field_decoder_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  ufd_pkg::t_in  i_in_data,
    output logic          o_in_stall,
    output logic          o_out_valid,
    output ufd_pkg::t_out o_out_data,
    input  logic          i_out_stall
);
    import ufd_pkg::*;

    logic    q_push;
    logic    q_full;
    logic    q_pop;
    logic    q_empty;
    t_bundle q_wdata;
    t_bundle q_rdata;

    ufd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_data   (q_wdata)
    );

    ufd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_rdata)
    );

    ufd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_data    (q_rdata),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule
